// ===== hdl/voice_channel_allocator_core_macros.svh =====
// Assertion macros for the voice channel allocator.
// Included by the top level; no other dependencies.
`ifndef VOICE_CHANNEL_ALLOCATOR_CORE_MACROS_SVH
`define VOICE_CHANNEL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define VCA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vca assertion failed");

// Next-cycle implication, disabled during reset
`define VCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vca assertion failed");

`endif

// ===== hdl/vca_pkg.sv =====
// Shared types and constants for the voice channel allocator.
// Used by the controller, the datapath and the top level.
package vca_pkg;

   localparam int CMD_W     = 2;
   localparam int NOTE_W    = 7;
   localparam int CHAN_OUT_W = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ALL_OFF  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NOTE_W-1:0] note;
   } req_type;

   typedef struct packed {
      logic [CHAN_OUT_W-1:0] channel;
      logic                  key_on;
      logic                  last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // latch the request
      logic dispatch;   // load target and pending mask
      logic steal;      // key-off at steal pointer, advance pointer
      logic key_on;     // store note, key-on at target
      logic scan_step;  // key-off lowest pending channel
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             any_free;
      logic             pend_any;
      logic             out_free;
   } sts_type;

endpackage

// ===== hdl/vca_datapath.sv =====
// Datapath: channel note table, steal pointer, pending mask and result register.
// Depends on vca_pkg; driven by vca_ctrl through ctl_type/sts_type.
module vca_datapath #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  vca_pkg::req_type  req_payload,
   input  vca_pkg::ctl_type  ctl,
   output vca_pkg::sts_type  sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output vca_pkg::rsp_type  rsp_payload
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [vca_pkg::CMD_W-1:0]  cmd_ff;
   logic [vca_pkg::NOTE_W-1:0] note_ff;
   logic [vca_pkg::NOTE_W-1:0] chan_note_ff [CHANNELS];
   logic [CHANNELS-1:0]        held_ff, held_in;
   logic [CHANNELS-1:0]        pend_ff, pend_in;
   logic [CH_W-1:0]            ptr_ff, ptr_in;
   logic [CH_W-1:0]            target_ff, target_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   vca_pkg::rsp_type           rsp_ff, rsp_in;

   logic [CHANNELS-1:0] match;
   logic [CHANNELS-1:0] pend_oh;
   logic [CHANNELS-1:0] pend_rest;
   logic [CH_W-1:0]     free_idx;
   logic [CH_W-1:0]     pend_idx;
   logic                push;

   // Lowest free channel and lowest pending channel
   always_comb begin
      free_idx = '0;
      pend_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (!held_ff[i]) begin
            free_idx = CH_W'(i);
         end
         if (pend_ff[i]) begin
            pend_idx = CH_W'(i);
         end
      end
   end

   // Per-channel note compare and pending one-hot
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         match[i]   = held_ff[i] && (chan_note_ff[i] == note_ff);
         pend_oh[i] = (pend_idx == CH_W'(i));
      end
   end

   assign pend_rest = pend_ff & ~pend_oh;
   assign push      = ctl.steal | ctl.key_on | ctl.scan_step;

   // Next-state logic
   always_comb begin
      held_in   = held_ff;
      pend_in   = pend_ff;
      ptr_in    = ptr_ff;
      target_in = target_ff;
      if (ctl.dispatch) begin
         target_in = free_idx;
         pend_in   = (cmd_ff == vca_pkg::CMD_ALL_OFF) ? '1 : match;
      end
      if (ctl.steal) begin
         target_in = ptr_ff;
         ptr_in    = (ptr_ff == CH_W'(CHANNELS - 1)) ? '0 : ptr_ff + 1'b1;
      end
      if (ctl.key_on) begin
         held_in[target_ff] = 1'b1;
      end
      if (ctl.scan_step) begin
         held_in = held_ff & ~pend_oh;
         pend_in = pend_rest;
      end
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.steal) begin
         rsp_in.channel = vca_pkg::CHAN_OUT_W'(ptr_ff);
         rsp_in.key_on  = 1'b0;
         rsp_in.last    = 1'b0;
      end else if (ctl.key_on) begin
         rsp_in.channel = vca_pkg::CHAN_OUT_W'(target_ff);
         rsp_in.key_on  = 1'b1;
         rsp_in.last    = 1'b1;
      end else if (ctl.scan_step) begin
         rsp_in.channel = vca_pkg::CHAN_OUT_W'(pend_idx);
         rsp_in.key_on  = 1'b0;
         rsp_in.last    = (pend_rest == '0);
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         pend_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
      if (ctl.accept) begin
         cmd_ff  <= req_payload.cmd;
         note_ff <= req_payload.note;
      end
      if (ctl.key_on) begin
         chan_note_ff[target_ff] <= note_ff;
      end
   end

   assign sts.cmd      = cmd_ff;
   assign sts.any_free = ~&held_ff;
   assign sts.pend_any = |pend_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/vca_ctrl.sv =====
// Controller state machine for the voice channel allocator.
// Depends on vca_pkg; commands vca_datapath.
module vca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vca_pkg::sts_type  sts,
   output vca_pkg::ctl_type  ctl
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_STEAL    = 5'b00100,
      ST_KEYON    = 5'b01000,
      ST_SCAN     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            ctl.dispatch = 1'b1;
            unique case (sts.cmd) inside
               vca_pkg::CMD_NOTE_ON: begin
                  state_in = sts.any_free ? ST_KEYON : ST_STEAL;
               end
               vca_pkg::CMD_NOTE_OFF, vca_pkg::CMD_ALL_OFF: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_STEAL: begin
            if (sts.out_free) begin
               ctl.steal = 1'b1;
               state_in  = ST_KEYON;
            end
         end
         ST_KEYON: begin
            if (sts.out_free) begin
               ctl.key_on = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!sts.pend_any) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               ctl.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/voice_channel_allocator_core.sv =====
// Channel   Direction  Fields               Handshake
// req       in         cmd, note            req_valid / req_ready
// rsp       out        channel, key_on, last rsp_valid / rsp_ready
//
// One request at a time. Note-on emits a key-on, preceded by a key-off when a channel
// is stolen; note-off emits a key-off per matching channel, all-off one per channel;
// the sequencer emits one result per cycle into a single output register.
// Reset frees every channel and zeroes the steal pointer.
// A stalled rsp holds the sequencer; the next request is taken once the last
// result is in the output register.
//
// Top level; depends on vca_pkg, vca_ctrl, vca_datapath and the macros header.
`include "voice_channel_allocator_core_macros.svh"

module voice_channel_allocator_core #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vca_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vca_pkg::rsp_type  rsp_payload
);

   vca_pkg::ctl_type ctl;
   vca_pkg::sts_type sts;

   vca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   vca_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A transfer in starts a busy period
   `VCA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // While idle, any waiting result must be the final one of its request
   `VCA_ASSERT_SAME(a_idle_last, clock, reset, req_ready && rsp_valid, rsp_payload.last)
   // A key-on always ends its request
   `VCA_ASSERT_SAME(a_keyon_last, clock, reset, rsp_valid && rsp_payload.key_on,
                    rsp_payload.last)

endmodule

// ===== tb/voice_check_pkg.sv =====
// Scoreboard for the voice channel allocator: tracks channel occupancy and
// the steal pointer, and queues the key events each request should produce.
// Depends on vca_pkg for the request, response and command definitions.
package voice_check_pkg;

   localparam int VOICES = 8;

   class voice_scoreboard;

      bit                        held[VOICES];
      bit [vca_pkg::NOTE_W-1:0]  held_note[VOICES];
      int unsigned               steal_ptr;
      vca_pkg::rsp_type          key_events[$];
      int unsigned               mismatches;

      function new();
         for (int i = 0; i < VOICES; i++) begin
            held[i]      = 1'b0;
            held_note[i] = '0;
         end
         steal_ptr  = 0;
         mismatches = 0;
      endfunction

      // Predict the key events for one accepted request
      function void note_request(vca_pkg::req_type r);
         int unsigned      chans[VOICES];
         bit               ons[VOICES];
         int               n;
         int               target;
         vca_pkg::rsp_type ev;
         n      = 0;
         target = -1;
         case (r.cmd)
            vca_pkg::CMD_NOTE_ON: begin
               for (int i = 0; i < VOICES; i++)
                  if (!held[i] && target < 0) target = i;
               // all busy: key off the voice at the steal pointer first
               if (target < 0) begin
                  target    = steal_ptr;
                  steal_ptr = (steal_ptr + 1) % VOICES;
                  chans[n]  = target;
                  ons[n]    = 1'b0;
                  n++;
               end
               held[target]      = 1'b1;
               held_note[target] = r.note;
               chans[n] = target;
               ons[n]   = 1'b1;
               n++;
            end
            vca_pkg::CMD_NOTE_OFF: begin
               for (int i = 0; i < VOICES; i++)
                  if (held[i] && held_note[i] == r.note) begin
                     chans[n] = i;
                     ons[n]   = 1'b0;
                     n++;
                     held[i]      = 1'b0;
                     held_note[i] = '0;
                  end
            end
            vca_pkg::CMD_ALL_OFF: begin
               for (int i = 0; i < VOICES; i++) begin
                  chans[n] = i;
                  ons[n]   = 1'b0;
                  n++;
                  held[i]      = 1'b0;
                  held_note[i] = '0;
               end
            end
            default: ;  // unused command: no effect
         endcase
         for (int k = 0; k < n; k++) begin
            ev.channel = chans[k][vca_pkg::CHAN_OUT_W-1:0];
            ev.key_on  = ons[k];
            ev.last    = (k == n - 1);
            key_events.insert(key_events.size(), ev);
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one transfer on the response channel with the oldest event
      task check_event(vca_pkg::rsp_type got);
         vca_pkg::rsp_type exp;
         if (key_events.size() == 0) begin
            report_mismatch($sformatf("unexpected key event ch=%0d on=%0b last=%0b",
                                      got.channel, got.key_on, got.last));
         end else begin
            exp = key_events.pop_front();
            if (got.channel !== exp.channel)
               report_mismatch($sformatf("channel got %0d want %0d",
                                         got.channel, exp.channel));
            if (got.key_on !== exp.key_on)
               report_mismatch($sformatf("key_on got %0b want %0b (ch %0d)",
                                         got.key_on, exp.key_on, exp.channel));
            if (got.last !== exp.last)
               report_mismatch($sformatf("last got %0b want %0b (ch %0d)",
                                         got.last, exp.last, exp.channel));
         end
      endtask

      function int unsigned outstanding();
         return key_events.size();
      endfunction

   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for voice_channel_allocator_core: directed and random
// note traffic with idle and backpressure phases. Depends on vca_pkg and
// voice_check_pkg.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 40;
   localparam logic [vca_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   vca_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   vca_pkg::rsp_type rsp_payload;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;

   voice_check_pkg::voice_scoreboard sb;

   voice_channel_allocator_core #(
      .CHANNELS(voice_check_pkg::VOICES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[voice_channel_allocator_core] ERROR");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Monitor both channels; response checked before the new request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_event(rsp_payload);
         if (req_valid && req_ready) sb.note_request(req_payload);
      end
   end

   function automatic vca_pkg::req_type make_req(logic [vca_pkg::CMD_W-1:0] cmd,
                                                 int unsigned note);
      vca_pkg::req_type r;
      r.cmd  = cmd;
      r.note = note[vca_pkg::NOTE_W-1:0];
      return r;
   endfunction

   // Mostly note traffic on a small pool so note-offs hit and voices get stolen
   function automatic vca_pkg::req_type random_request();
      int unsigned pick;
      int unsigned note;
      pick = $urandom_range(0, 99);
      note = ($urandom_range(0, 9) < 7) ? 60 + $urandom_range(0, 5)
                                        : $urandom_range(0, 127);
      if (pick < 55) return make_req(vca_pkg::CMD_NOTE_ON, note);
      else if (pick < 88) return make_req(vca_pkg::CMD_NOTE_OFF, note);
      else if (pick < 95) return make_req(vca_pkg::CMD_ALL_OFF, $urandom_range(0, 127));
      else return make_req(CMD_UNUSED, $urandom_range(0, 127));
   endfunction

   // Offer one request and wait for its transfer
   task automatic send_request(vca_pkg::req_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // One edge first so the monitor has noted the last accepted request
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_request(random_request());
      drain_results();
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_idle_pct = 58;

      // Directed: no-effect requests on an empty allocator
      send_request(make_req(vca_pkg::CMD_NOTE_OFF, 5));
      send_request(make_req(CMD_UNUSED, 127));
      // fill every voice, including a repeated note and the note extremes
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 0));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 127));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 127));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 60));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 1));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 2));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 64));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 85));
      // all busy: two steals advance the pointer
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 99));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 42));
      // release the surviving repeat, then reuse the lowest free voice
      send_request(make_req(vca_pkg::CMD_NOTE_OFF, 127));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 7));
      // all-off on a full and on an empty allocator
      send_request(make_req(vca_pkg::CMD_ALL_OFF, 127));
      send_request(make_req(vca_pkg::CMD_ALL_OFF, 0));
      send_request(make_req(vca_pkg::CMD_NOTE_OFF, 0));
      // one note on three voices, released by a single note-off
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 33));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 33));
      send_request(make_req(vca_pkg::CMD_NOTE_ON, 33));
      send_request(make_req(vca_pkg::CMD_NOTE_OFF, 33));
      send_request(make_req(CMD_UNUSED, 0));
      drain_results();

      // Long receiver hold-off while requests keep coming, then a full drain
      hold_requests++;
      repeat (12) send_request(make_req(vca_pkg::CMD_NOTE_ON, $urandom_range(0, 127)));
      send_request(make_req(vca_pkg::CMD_ALL_OFF, 0));
      drain_results();

      random_phase(42, 12, 58);
      random_phase(42, 58, 12);
      random_phase(42, 0, 0);

      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("[voice_channel_allocator_core] OK");
      end else begin
         $display("[voice_channel_allocator_core] ERROR");
      end
      $finish;
   end

endmodule
